// File: rtl/perspective_point_projection_unit_assert.svh
// assertion macros for the projection unit
`ifndef PERSPECTIVE_POINT_PROJECTION_UNIT_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_UNIT_ASSERT_SVH
// plain implication checked on every clock edge outside reset
`define PPP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// signal must never be unknown outside reset
`define PPP_ASSERT_KNOWN(label, clk, rst_n, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) else $error(msg);
`endif

// File: rtl/ppp_pkg.sv
// shared constants and types for the projection unit
`timescale 1ns / 1ps
package ppp_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned DivStages = 32;
  localparam int unsigned FifoDepthDefault = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegCamX = 3'd0, RegCamY = 3'd1, RegCamZ = 3'd2, RegRow0 = 3'd3,
    RegRow1 = 3'd4, RegRow2 = 3'd5, RegFocal = 3'd6, RegNone = 3'd7
  } reg_idx_e;

  // camera-space item passed from front to back
  typedef struct packed {
    logic signed [51:0] cx;
    logic signed [51:0] cy;
    logic signed [51:0] cz;
  } cam_pt_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic in_front;
    logic clipped;
  } result_t;
endpackage

// File: rtl/ppp_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
interface ppp_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ppp_front.sv
// front: subtract camera location and rotate, two pipeline stages
`timescale 1ns / 1ps
module ppp_front (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [95:0] in_data_i,
  input  logic [31:0] cam_x_i,
  input  logic [31:0] cam_y_i,
  input  logic [31:0] cam_z_i,
  input  logic [47:0] row0_i,
  input  logic [47:0] row1_i,
  input  logic [47:0] row2_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ppp_pkg::cam_pt_t out_data_o
);
  import ppp_pkg::*;
  logic s1_valid_q, s2_valid_q, adv1, adv2;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [47:0] p_q [9];
  logic signed [47:0] p_d [9];
  logic [47:0] rows [3];
  cam_pt_t pt_q;

  assign adv2 = !s2_valid_q || out_ready_i;
  assign adv1 = !s1_valid_q || adv2;
  assign in_ready_o = adv1;
  assign rows[0] = row0_i;
  assign rows[1] = row1_i;
  assign rows[2] = row2_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p_d[r*3+0] = 48'(signed'(rows[r][15:0]) * dx_q);
      p_d[r*3+1] = 48'(signed'(rows[r][31:16]) * dy_q);
      p_d[r*3+2] = 48'(signed'(rows[r][47:32]) * dz_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= in_valid_i;
      if (adv2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      dx_q <= 33'(signed'(in_data_i[31:0])) - 33'(signed'(cam_x_i));
      dy_q <= 33'(signed'(in_data_i[63:32])) - 33'(signed'(cam_y_i));
      dz_q <= 33'(signed'(in_data_i[95:64])) - 33'(signed'(cam_z_i));
    end
    if (adv2 && s1_valid_q) begin
      for (int k = 0; k < 9; k++) p_q[k] <= p_d[k];
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o.cx = 52'(p_q[0]) + 52'(p_q[1]) + 52'(p_q[2]);
  assign out_data_o.cy = 52'(p_q[3]) + 52'(p_q[4]) + 52'(p_q[5]);
  assign out_data_o.cz = 52'(p_q[6]) + 52'(p_q[7]) + 52'(p_q[8]);
endmodule

// File: rtl/ppp_fifo.sv
// short queue between front and back
`timescale 1ns / 1ps
module ppp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [Width-1:0] out_data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != (AW+1)'(Depth);
  assign out_valid_o = cnt_q != '0;
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end
endmodule

// File: rtl/ppp_back.sv
// back: focal multiply then pipelined restoring division, one quotient bit per stage
`timescale 1ns / 1ps
module ppp_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  ppp_pkg::cam_pt_t in_data_i,
  input  logic [31:0] focal_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output ppp_pkg::result_t out_data_o
);
  import ppp_pkg::*;
  `include "perspective_point_projection_unit_assert.svh"
  localparam int unsigned NS = DivStages;
  localparam logic [33:0] QCap = 34'h200000000;

  typedef struct packed {
    logic front;
    logic nx;
    logic ny;
    logic [50:0] d;
    logic [82:0] nrx;
    logic [82:0] nry;
    logic [33:0] qx;
    logic [33:0] qy;
  } dstg_t;

  logic adv;
  logic m_valid_q;
  logic m_front_q, m_nx_q, m_ny_q;
  logic [50:0] ax_q, ay_q, m_d_q;
  logic [31:0] m_focal_q;
  logic p_valid_q;
  logic p_front_q, p_nx_q, p_ny_q;
  logic [50:0] p_d_q;
  logic [56:0] plx_q, ply_q;
  logic [57:0] phx_q, phy_q;
  logic mm_valid_q;
  dstg_t mm_q;
  dstg_t st0_d;
  logic [NS:0] v_q;
  dstg_t st_q [NS+1];
  dstg_t st_d [NS];
  logic [51:0] rx_w [NS];
  logic [51:0] ry_w [NS];
  logic gx_w [NS];
  logic gy_w [NS];
  logic o_valid_q;
  result_t o_q;
  logic [51:0] ncx, ncy;

  assign adv = !o_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign ncx = -in_data_i.cx;
  assign ncy = -in_data_i.cy;

  // quotient at or above 2^32 saturates either way, so flag it before dividing
  always_comb begin
    st0_d = mm_q;
    st0_d.qx = (mm_q.nrx[82:32] >= mm_q.d) ? QCap : '0;
    st0_d.qy = (mm_q.nry[82:32] >= mm_q.d) ? QCap : '0;
  end

  // remainder lives in the upper bits of the numerator, low 32 bits shift in
  always_comb begin
    for (int s = 0; s < NS; s++) begin
      rx_w[s] = {st_q[s].nrx[82:32], st_q[s].nrx[31-s]};
      ry_w[s] = {st_q[s].nry[82:32], st_q[s].nry[31-s]};
      gx_w[s] = rx_w[s] >= {1'b0, st_q[s].d};
      gy_w[s] = ry_w[s] >= {1'b0, st_q[s].d};
      st_d[s] = st_q[s];
      st_d[s].nrx[82:32] = gx_w[s] ? 51'(rx_w[s] - {1'b0, st_q[s].d}) : rx_w[s][50:0];
      st_d[s].nry[82:32] = gy_w[s] ? 51'(ry_w[s] - {1'b0, st_q[s].d}) : ry_w[s][50:0];
      if (!st_q[s].qx[33]) st_d[s].qx = {st_q[s].qx[32:0], gx_w[s]};
      if (!st_q[s].qy[33]) st_d[s].qy = {st_q[s].qy[32:0], gy_w[s]};
    end
  end

  function automatic result_t finish(input dstg_t f);
    result_t r;
    r = '0;
    if (f.front) begin
      r.in_front = 1'b1;
      if (!f.nx) begin
        if (f.qx > 34'h080000000) begin
          r.screen_x = 32'sh80000000;
          r.clipped = 1'b1;
        end else r.screen_x = 32'(-f.qx);
      end else if (f.qx > 34'h07fffffff) begin
        r.screen_x = 32'sh7fffffff;
        r.clipped = 1'b1;
      end else r.screen_x = f.qx[31:0];
      if (!f.ny) begin
        if (f.qy > 34'h080000000) begin
          r.screen_y = 32'sh80000000;
          r.clipped = 1'b1;
        end else r.screen_y = 32'(-f.qy);
      end else if (f.qy > 34'h07fffffff) begin
        r.screen_y = 32'sh7fffffff;
        r.clipped = 1'b1;
      end else r.screen_y = f.qy[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      mm_valid_q <= 1'b0;
      v_q <= '0;
      o_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= in_valid_i;
      p_valid_q <= m_valid_q;
      mm_valid_q <= p_valid_q;
      v_q <= {v_q[NS-1:0], mm_valid_q};
      o_valid_q <= v_q[NS];
    end
  end

  // focal product split into two partial products, summed one stage later
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_front_q <= in_data_i.cz[51];
      m_nx_q <= in_data_i.cx[51];
      m_ny_q <= in_data_i.cy[51];
      ax_q <= in_data_i.cx[51] ? ncx[50:0] : in_data_i.cx[50:0];
      ay_q <= in_data_i.cy[51] ? ncy[50:0] : in_data_i.cy[50:0];
      m_d_q <= 51'(-in_data_i.cz);
      m_focal_q <= focal_i;
      p_front_q <= m_front_q;
      p_nx_q <= m_nx_q;
      p_ny_q <= m_ny_q;
      p_d_q <= m_d_q;
      plx_q <= 57'(ax_q[24:0]) * 57'(m_focal_q);
      ply_q <= 57'(ay_q[24:0]) * 57'(m_focal_q);
      phx_q <= 58'(ax_q[50:25]) * 58'(m_focal_q);
      phy_q <= 58'(ay_q[50:25]) * 58'(m_focal_q);
      mm_q.front <= p_front_q;
      mm_q.nx <= p_nx_q;
      mm_q.ny <= p_ny_q;
      mm_q.d <= p_d_q;
      mm_q.nrx <= (83'(phx_q) << 25) + 83'(plx_q);
      mm_q.nry <= (83'(phy_q) << 25) + 83'(ply_q);
      mm_q.qx <= '0;
      mm_q.qy <= '0;
      st_q[0] <= st0_d;
      for (int s = 0; s < NS; s++) st_q[s+1] <= st_d[s];
      o_q <= finish(st_q[NS]);
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o = o_q;

  `PPP_ASSERT(a_hidden_zero, clk_i, rst_ni,
    (o_valid_q && !o_q.in_front) |-> (o_q.screen_x == 0 && o_q.screen_y == 0 && !o_q.clipped),
    "point behind camera gave nonzero result")
  `PPP_ASSERT(a_hold_stall, clk_i, rst_ni,
    (o_valid_q && !out_ready_i) |=> (o_valid_q && $stable(o_q)), "result changed under stall")
  `PPP_ASSERT(a_pipe_flow, clk_i, rst_ni,
    (adv && v_q[NS]) |=> o_valid_q, "item lost at pipe end")
  `PPP_ASSERT_KNOWN(a_valid_known, clk_i, rst_ni, o_valid_q, "result valid unknown")
endmodule

// File: rtl/perspective_point_projection_unit.sv
// top level: config registers, front, queue and back
`timescale 1ns / 1ps
// Perspective projection of one world point per item.
// Channels: cfg_if (idx, 48-bit data) writes the seven registers;
// pt_if carries point_x/y/z (Q16.16), res_if carries screen_x/y, in_front, clipped.
// Throughput: one item per cycle while the receiver does not stall, set by
// the fully pipelined front (two stages) and back (three multiply stages,
// a range check stage, 32 division stages and an output register).
// An accepted item's result is valid once it has passed all of these stages,
// plus any time it waits in the queue.
// The queue between front and back is FifoDepth items deep.
// Reset puts the camera at the origin, rotation to identity, focal length 1.0,
// and empties all stages; nothing is cleared in any memory.
// When the receiver stalls the back holds in place, the queue fills,
// and then the front and the input stop accepting items.
// Configuration writes are always accepted and should come only when idle.
module perspective_point_projection_unit #(
  parameter int unsigned FifoDepth = ppp_pkg::FifoDepthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  ppp_if.sink cfg_if,
  ppp_if.sink pt_if,
  ppp_if.source res_if
);
  import ppp_pkg::*;
  logic [31:0] cam_x_q, cam_y_q, cam_z_q, focal_q;
  logic [47:0] row0_q, row1_q, row2_q;
  logic f_valid, f_ready, b_valid, b_ready;
  cam_pt_t f_data, b_data;
  result_t res;
  reg_idx_e idx;

  assign cfg_if.ready = 1'b1;
  assign idx = reg_idx_e'(cfg_if.data[CfgIdxW+CfgDataW-1:CfgDataW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      row0_q <= 48'h4000;
      row1_q <= 48'h40000000;
      row2_q <= 48'h400000000000;
      focal_q <= 32'h10000;
    end else if (cfg_if.valid) begin
      unique case (idx)
        RegCamX: cam_x_q <= cfg_if.data[31:0];
        RegCamY: cam_y_q <= cfg_if.data[31:0];
        RegCamZ: cam_z_q <= cfg_if.data[31:0];
        RegRow0: row0_q <= cfg_if.data[47:0];
        RegRow1: row1_q <= cfg_if.data[47:0];
        RegRow2: row2_q <= cfg_if.data[47:0];
        RegFocal: focal_q <= cfg_if.data[31:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(pt_if.valid), .in_ready_o(pt_if.ready), .in_data_i(pt_if.data),
    .cam_x_i(cam_x_q), .cam_y_i(cam_y_q), .cam_z_i(cam_z_q),
    .row0_i(row0_q), .row1_i(row1_q), .row2_i(row2_q),
    .out_valid_o(f_valid), .out_ready_i(f_ready), .out_data_o(f_data)
  );

  ppp_fifo #(.Width($bits(cam_pt_t)), .Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i(f_data),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(b_data)
  );

  ppp_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i(b_valid), .in_ready_o(b_ready), .in_data_i(b_data),
    .focal_i(focal_q),
    .out_valid_o(res_if.valid), .out_ready_i(res_if.ready), .out_data_o(res)
  );

  assign res_if.data = res;
endmodule

// File: verif/tb_perspective_point_projection_unit.sv
// self-checking testbench for the perspective point projection unit
`timescale 1ns / 1ps
module tb_perspective_point_projection_unit;
  import ppp_pkg::*;

  localparam int unsigned CfgW = CfgIdxW + CfgDataW;
  localparam int unsigned PtW = 96;
  localparam int unsigned ResW = $bits(result_t);
  localparam int unsigned HoldCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppp_if #(.W(CfgW)) cfg_if ();
  ppp_if #(.W(PtW)) pt_if ();
  ppp_if #(.W(ResW)) res_if ();

  perspective_point_projection_unit uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_if(cfg_if.sink),
    .pt_if(pt_if.sink),
    .res_if(res_if.source)
  );

  always #1 clk_i = ~clk_i;

  // shadow copy of the camera registers
  logic signed [31:0] cam_loc[3];
  logic [47:0] rot_row[3];
  logic [31:0] focal;

  result_t proj_q[$];
  int unsigned n_errors = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen;
  int unsigned hold_left;

  // focal*num/den, truncated toward zero and saturated; den is negative
  function automatic logic [31:0] scale_div(longint num, longint den, logic [31:0] f,
                                            inout logic sat);
    logic [127:0] mag;
    logic [127:0] q;
    mag = (num < 0) ? 128'(-num) : 128'(num);
    q = (mag * 128'(f)) / 128'(-den);
    if (num >= 0) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(0) - q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic result_t project_point(logic signed [31:0] px, logic signed [31:0] py,
                                            logic signed [31:0] pz);
    longint d[3];
    longint c[3];
    logic sat;
    result_t r;
    sat = 1'b0;
    d[0] = longint'(px) - longint'(cam_loc[0]);
    d[1] = longint'(py) - longint'(cam_loc[1]);
    d[2] = longint'(pz) - longint'(cam_loc[2]);
    for (int i = 0; i < 3; i++) begin
      c[i] = 0;
      for (int j = 0; j < 3; j++)
        c[i] += longint'($signed(rot_row[i][16*j +: 16])) * d[j];
    end
    r = '0;
    if (c[2] < 0) begin
      r.screen_x = scale_div(c[0], c[2], focal, sat);
      r.screen_y = scale_div(c[1], c[2], focal, sat);
      r.in_front = 1'b1;
      r.clipped = sat;
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [47:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= {idx, val};
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      RegCamX, RegCamY, RegCamZ: cam_loc[idx] = val[31:0];
      RegRow0, RegRow1, RegRow2: rot_row[idx - RegRow0] = val;
      RegFocal: focal = val[31:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    int unsigned gap;
    pt_if.valid <= 1'b1;
    pt_if.data <= {pz, py, px};
    do @(posedge clk_i); while (!pt_if.ready);
    proj_q.insert(proj_q.size(), project_point(px, py, pz));
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(4, 1);
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    while (proj_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // receiver side: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (proj_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = proj_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: x %h/%h y %h/%h front %b/%b clip %b/%b (exp/got)",
                     want.screen_x, got.screen_x, want.screen_y, got.screen_y,
                     want.in_front, got.in_front, want.clipped, got.clipped);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [47:0] rand_row();
    logic [47:0] r;
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = ($urandom_range(3) == 0) ? 16'($urandom())
                                               : 16'($signed($urandom_range(32768)) - 16384);
    return r;
  endfunction

  task automatic test_reset_defaults();
    send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_point('0, '0, '0);
    drain();
  endtask

  // extremes, level/behind points, saturation and the exact negative limit
  task automatic test_directed();
    send_point(32'h0000_8000, 32'h0, 32'hFFFF_FFFF);
    send_point(32'h0000_8001, 32'h0, 32'hFFFF_FFFF);
    send_point(32'hFFFF_8000, 32'hFFFF_7FFF, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    write_reg(RegCamX, 48'h0000_7FFF_FFFF);
    write_reg(RegCamY, 48'h0000_8000_0000);
    write_reg(RegCamZ, 48'h0000_7FFF_FFFF);
    write_reg(RegRow0, 48'h8000_7FFF_C000);
    write_reg(RegRow1, 48'h7FFF_8000_4000);
    write_reg(RegRow2, 48'h7FFF_7FFF_7FFF);
    write_reg(RegFocal, 48'h0000_FFFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(RegFocal, 48'h0);
    send_point(32'h0003_0000, 32'hFFFD_0000, 32'h8000_0000);
    drain();
    // out-of-range index must leave everything alone
    write_reg(RegNone, 48'hFFFF_FFFF_FFFF);
    write_reg(RegFocal, 48'hFFFF_0001_0000);
    write_reg(RegCamX, '0);
    write_reg(RegCamY, '0);
    write_reg(RegCamZ, '0);
    write_reg(RegRow0, 48'h0000_0000_4000);
    write_reg(RegRow1, 48'h0000_4000_0000);
    write_reg(RegRow2, 48'h4000_0000_0000);
    send_point(32'h0005_0000, 32'hFFFB_0000, 32'hFFFE_0000);
    drain();
  endtask

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    write_reg(RegCamX, 48'(rand_coord()));
    write_reg(RegCamY, 48'(rand_coord()));
    write_reg(RegCamZ, 48'(rand_coord()));
    write_reg(RegRow0, rand_row());
    write_reg(RegRow1, rand_row());
    write_reg(RegRow2, rand_row());
    write_reg(RegFocal, ($urandom_range(3) == 0) ? 48'($urandom())
                                                 : 48'($urandom_range(32'h0040_0000)));
    repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  task automatic test_random();
    random_phase(185, 0, 0);
    random_phase(185, 60, 0);
    random_phase(185, 0, 60);
    random_phase(185, 20, 20);
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    repeat (100) send_point(rand_coord(), rand_coord(), 32'($urandom_range(1 << 20)) | 32'h8000_0000);
    drain();
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    pt_if.valid = 1'b0;
    pt_if.data = '0;
    cam_loc = '{default: '0};
    rot_row[0] = 48'h0000_0000_4000;
    rot_row[1] = 48'h0000_4000_0000;
    rot_row[2] = 48'h4000_0000_0000;
    focal = 32'h0001_0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random();
    test_backpressure();
    if (n_errors == 0 && proj_q.size() == 0) begin
      $display("tb_perspective_point_projection_unit: done, clean");
    end else begin
      $display("tb_perspective_point_projection_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_perspective_point_projection_unit: done, errors");
    $finish;
  end
endmodule
